>>> hdl/lcp_pkg.sv
// ----------------------------------------------------------------------------
// lcp_pkg
// Shared types, constants and helpers for the coordinate-seeded lcg picker.
// ----------------------------------------------------------------------------
package lcp_pkg;

	localparam logic [63:0] LCG_MUL      = 64'h5851F42D4C957F2D;
	localparam logic [63:0] LCG_ADD      = 64'h14057B7EF767814F;
	localparam logic [63:0] HASH_MUL     = 64'd1284865837;
	localparam logic [63:0] HASH_SUB_NEG = 64'd0 - 64'd144211633;

	localparam logic [2:0] OP_POS   = 3'd0;
	localparam logic [2:0] OP_DRAW  = 3'd1;
	localparam logic [2:0] OP_PICK2 = 3'd2;
	localparam logic [2:0] OP_PICK4 = 3'd3;
	localparam logic [2:0] OP_MODE  = 3'd4;

	// configuration register indexes
	localparam logic REG_SALT  = 1'b0;
	localparam logic REG_WORLD = 1'b1;

	// microcode step ranges of the shared multiply-add unit
	localparam logic [4:0] STEP_DERIVE_FIRST = 5'd0;
	localparam logic [4:0] STEP_DERIVE_LAST  = 5'd11;
	localparam logic [4:0] STEP_POS_FIRST    = 5'd12;
	localparam logic [4:0] STEP_POS_LAST     = 5'd21;
	localparam logic [4:0] STEP_DRAW_FIRST   = 5'd22;
	localparam logic [4:0] STEP_DRAW_LAST    = 5'd23;

	typedef struct packed {
		logic        start;
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] z;
	} mac_req_t;

	// majority rule over four values: {hit, value}
	function automatic logic [8:0] mode_of(input logic [7:0] i, input logic [7:0] j,
		input logic [7:0] k, input logic [7:0] l);
		logic [8:0] r;
		r = {1'b0, 8'd0};
		if (j == k && k == l) r = {1'b1, j};
		else if (i == j && j == k) r = {1'b1, i};
		else if (i == j && j == l) r = {1'b1, i};
		else if (i == k && k == l) r = {1'b1, i};
		else if (i == j && k != l) r = {1'b1, i};
		else if (i == k && j != l) r = {1'b1, i};
		else if (i == l && j != k) r = {1'b1, i};
		else if (j == k && i != l) r = {1'b1, j};
		else if (j == l && i != k) r = {1'b1, j};
		else if (k == l && i != j) r = {1'b1, k};
		return r;
	endfunction

endpackage

>>> hdl/lcp_mac.sv
// ----------------------------------------------------------------------------
// lcp_mac
// 64-bit wrapping multiply-add x*y+z, one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
module lcp_mac (
	input  logic             clk,
	input  logic             arst_n,
	input  lcp_pkg::mac_req_t req,
	output logic             done,
	output logic [63:0]      acc
);

	logic        busy_q;
	logic [1:0]  phase_q;
	logic        done_q;
	logic [63:0] acc_q;
	logic [31:0] ma;
	logic [31:0] mb;
	logic [63:0] prod;

	always_comb begin
		case (phase_q)
			2'd0: begin
				ma = req.x[31:0];
				mb = req.y[31:0];
			end
			2'd1: begin
				ma = req.x[31:0];
				mb = req.y[63:32];
			end
			default: begin
				ma = req.x[63:32];
				mb = req.y[31:0];
			end
		endcase
	end

	assign prod = {32'd0, ma} * {32'd0, mb};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 2'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				if (phase_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				phase_q <= phase_q + 2'd1;
			end else if (req.start) begin
				busy_q  <= 1'b1;
				phase_q <= 2'd0;
			end
		end
	end

	// cross products only reach the upper word
	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (phase_q == 2'd0) acc_q <= req.z + prod;
			else acc_q <= acc_q + {prod[31:0], 32'd0};
		end
	end

	assign done = done_q;
	assign acc  = acc_q;

endmodule

>>> hdl/coordinate_seeded_lcg_picker.sv
// ----------------------------------------------------------------------------
// coordinate_seeded_lcg_picker
// Position-seeded random generator on a 64-bit quadratic lcg.
// ----------------------------------------------------------------------------
// All 64-bit arithmetic runs on one shared multiply-add unit that builds each
// product from three 32x32 partial products. A position word takes 10
// multiply-adds. Draw and random picks run a one-bit-per-cycle restoring
// remainder on the 40-bit shifted running value, then 2 multiply-adds to
// advance it. Mode-or-random words with a majority and unused operation codes
// finish in the accept cycle. A configuration write recomputes the mixed salt
// and layer seed, with input held off.
module coordinate_seeded_lcg_picker #(
	parameter int MAX_BOUND = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic [12:0] bound,
	input  logic [7:0]  value_a,
	input  logic [7:0]  value_b,
	input  logic [7:0]  value_c,
	input  logic [7:0]  value_d,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] result_value
);

	localparam logic [16:0] MaxB    = 17'(MAX_BOUND);
	localparam int          DivBits = 40;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ISSUE = 4'b0010,
		ST_WAIT  = 4'b0100,
		ST_DIV   = 4'b1000
	} state_t;

	typedef enum logic [2:0] {
		DST_T, DST_V, DST_U, DST_MIX, DST_SEED, DST_RUN
	} dst_t;

	state_t      state_q;
	logic [4:0]  step_q;
	logic [63:0] salt_q, wseed_q, mix_q, seed_q, run_q;
	logic [63:0] xi_q, yi_q, t_q, v_q, u_q;
	logic [2:0]  op_q;
	logic [7:0]  a_q, b_q, c_q, d_q;
	logic [12:0] bnd_q;
	logic [39:0] dq_q;
	logic [12:0] rem_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic [11:0] res_q;
	logic        res_valid_q;

	lcp_pkg::mac_req_t req;
	dst_t        dst;
	logic        mac_done;
	logic [63:0] mac_acc;

	logic        in_acc, cfg_acc;
	logic [8:0]  mode_r;
	logic [12:0] eff_bnd;
	logic [39:0] sh, mag;
	logic [13:0] tr;
	logic [12:0] rem_d, r_d;
	logic [11:0] pick_d;
	logic        last_step;
	logic        res_fire;

	lcp_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.done   (mac_done),
		.acc    (mac_acc)
	);

	assign cfg_ready = (state_q == ST_IDLE);
	assign in_ready  = (state_q == ST_IDLE) && !cfg_valid && (!res_valid_q || out_ready);
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign in_acc    = in_valid && in_ready;
	assign out_valid = res_valid_q;
	assign result_value = res_q;

	assign mode_r = lcp_pkg::mode_of(value_a, value_b, value_c, value_d);

	always_comb begin
		if (bound == 13'd0) eff_bnd = 13'd1;
		else if ({4'd0, bound} > MaxB) eff_bnd = MaxB[12:0];
		else eff_bnd = bound;
	end

	assign sh  = run_q[63:24];
	assign mag = run_q[63] ? (40'd0 - sh) : sh;

	// one remainder bit per cycle
	assign tr    = {rem_q, dq_q[39]};
	assign rem_d = (tr >= {1'b0, bnd_q}) ? 13'(tr - {1'b0, bnd_q}) : tr[12:0];
	assign r_d   = neg_q ? ((rem_d == 13'd0) ? 13'd0 : bnd_q - rem_d) : rem_d;

	always_comb begin
		case (op_q)
			lcp_pkg::OP_DRAW:  pick_d = r_d[11:0];
			lcp_pkg::OP_PICK2: pick_d = {4'd0, (r_d == 13'd0) ? a_q : b_q};
			default: begin
				case (r_d[1:0])
					2'd0:    pick_d = {4'd0, a_q};
					2'd1:    pick_d = {4'd0, b_q};
					2'd2:    pick_d = {4'd0, c_q};
					default: pick_d = {4'd0, d_q};
				endcase
			end
		endcase
	end

	// microcode: dst = x * y + z
	always_comb begin
		req.start = (state_q == ST_ISSUE);
		req.x = lcp_pkg::LCG_MUL;
		req.y = v_q;
		req.z = lcp_pkg::LCG_ADD;
		dst   = DST_T;
		unique case (step_q)
			5'd0:  req.y = salt_q;
			5'd1:  begin req.x = salt_q; req.y = t_q; req.z = salt_q; dst = DST_V; end
			5'd2:  ;
			5'd3:  begin req.x = t_q; req.y = v_q; req.z = salt_q; dst = DST_V; end
			5'd4:  ;
			5'd5:  begin req.x = v_q; req.y = t_q; req.z = salt_q; dst = DST_MIX; end
			5'd6:  req.y = {wseed_q[31:0], wseed_q[31:0]};
			5'd7:  begin req.x = wseed_q; req.y = t_q; req.z = mix_q; dst = DST_V; end
			5'd8:  ;
			5'd9:  begin req.x = v_q; req.y = t_q; req.z = mix_q; dst = DST_V; end
			5'd10: ;
			5'd11: begin req.x = v_q; req.y = t_q; req.z = mix_q; dst = DST_SEED; end
			5'd12: req.y = seed_q;
			5'd13: begin req.x = t_q; req.y = seed_q; req.z = xi_q; dst = DST_V; end
			5'd14: begin req.x = lcp_pkg::HASH_MUL; req.z = lcp_pkg::HASH_SUB_NEG; end
			5'd15: begin req.x = v_q; req.y = t_q; req.z = yi_q; dst = DST_U; end
			5'd16: begin
				req.x = lcp_pkg::HASH_MUL; req.y = {32'd0, u_q[31:0]};
				req.z = lcp_pkg::HASH_SUB_NEG; dst = DST_U;
			end
			5'd17: ;
			5'd18: begin req.x = v_q; req.y = t_q; req.z = yi_q; end
			5'd19: begin
				req.x = {u_q[31:0], u_q[31:0]}; req.y = t_q; req.z = xi_q; dst = DST_V;
			end
			5'd20: begin
				req.x = lcp_pkg::HASH_MUL; req.y = {32'd0, v_q[31:0]};
				req.z = lcp_pkg::HASH_SUB_NEG; dst = DST_U;
			end
			5'd21: begin
				req.x = {u_q[31:0], u_q[31:0]}; req.y = v_q; req.z = yi_q; dst = DST_RUN;
			end
			5'd22: req.y = run_q;
			5'd23: begin req.x = run_q; req.y = t_q; req.z = seed_q; dst = DST_RUN; end
			default: ;
		endcase
	end

	assign last_step = (step_q == lcp_pkg::STEP_DERIVE_LAST) ||
		(step_q == lcp_pkg::STEP_POS_LAST) || (step_q == lcp_pkg::STEP_DRAW_LAST);

	// a result word is complete this cycle; out_valid is registered from it
	always_comb begin
		res_fire = 1'b0;
		if (state_q == ST_WAIT && mac_done && last_step &&
			step_q != lcp_pkg::STEP_DERIVE_LAST) res_fire = 1'b1;
		if (in_acc) begin
			unique case (operation)
				lcp_pkg::OP_POS, lcp_pkg::OP_DRAW, lcp_pkg::OP_PICK2,
				lcp_pkg::OP_PICK4: ;
				lcp_pkg::OP_MODE: res_fire = mode_r[8];
				default: res_fire = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= 5'd0;
			salt_q      <= 64'd0;
			wseed_q     <= 64'd0;
			mix_q       <= 64'd0;
			seed_q      <= 64'd0;
			run_q       <= 64'd0;
			cnt_q       <= 6'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_fire) res_valid_q <= 1'b1;
			else if (out_valid && out_ready) res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_acc) begin
						if (cfg_index == lcp_pkg::REG_SALT) salt_q <= cfg_data;
						else wseed_q <= {32'd0, cfg_data[31:0]};
						step_q  <= lcp_pkg::STEP_DERIVE_FIRST;
						state_q <= ST_ISSUE;
					end else if (in_acc) begin
						unique case (operation)
							lcp_pkg::OP_POS: begin
								step_q  <= lcp_pkg::STEP_POS_FIRST;
								state_q <= ST_ISSUE;
							end
							lcp_pkg::OP_DRAW, lcp_pkg::OP_PICK2, lcp_pkg::OP_PICK4: begin
								cnt_q   <= 6'd0;
								state_q <= ST_DIV;
							end
							lcp_pkg::OP_MODE: begin
								if (!mode_r[8]) begin
									cnt_q   <= 6'd0;
									state_q <= ST_DIV;
								end
							end
							default: ;
						endcase
					end
				end
				ST_ISSUE: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (mac_done) begin
						case (dst)
							DST_MIX:  mix_q  <= mac_acc;
							DST_SEED: seed_q <= mac_acc;
							DST_RUN:  run_q  <= mac_acc;
							default:  ;
						endcase
						if (last_step) begin
							state_q <= ST_IDLE;
						end else begin
							step_q  <= step_q + 5'd1;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(DivBits - 1)) begin
						step_q  <= lcp_pkg::STEP_DRAW_FIRST;
						state_q <= ST_ISSUE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q  <= operation;
			xi_q  <= {{32{pos_x[31]}}, pos_x};
			yi_q  <= {{32{pos_y[31]}}, pos_y};
			a_q   <= value_a;
			b_q   <= value_b;
			c_q   <= value_c;
			d_q   <= value_d;
			dq_q  <= mag;
			neg_q <= run_q[63];
			rem_q <= 13'd0;
			res_q <= (operation == lcp_pkg::OP_MODE && mode_r[8]) ?
				{4'd0, mode_r[7:0]} : 12'd0;
			if (operation == lcp_pkg::OP_DRAW) bnd_q <= eff_bnd;
			else if (operation == lcp_pkg::OP_PICK2) bnd_q <= 13'd2;
			else bnd_q <= 13'd4;
		end
		if (state_q == ST_DIV) begin
			rem_q <= rem_d;
			dq_q  <= {dq_q[38:0], 1'b0};
			if (cnt_q == 6'(DivBits - 1)) res_q <= pick_d;
		end
		if (state_q == ST_WAIT && mac_done) begin
			case (dst)
				DST_T:   t_q <= mac_acc;
				DST_V:   v_q <= mac_acc;
				DST_U:   u_q <= mac_acc;
				default: ;
			endcase
		end
	end

endmodule

>>> dv/coordinate_seeded_lcg_picker_tb.sv
// ----------------------------------------------------------------------------
// coordinate_seeded_lcg_picker_tb
// Self-checking bench: a directed table, then random words under several salt
// and world-seed settings. The monitor tracks the generator state from the
// accepted words and checks each result_value in order.
// ----------------------------------------------------------------------------
module coordinate_seeded_lcg_picker_tb;

	localparam int          MAX_BOUND  = 4096;
	localparam int          CYCLE_CAP  = 1_000_000;
	localparam int          DRAIN_WAIT = 80;
	localparam int          CHUNK      = 250;
	localparam logic [2:0]  OP_RSVD5   = 3'd5;
	localparam logic [2:0]  OP_RSVD6   = 3'd6;
	localparam logic [2:0]  OP_RSVD7   = 3'd7;
	localparam logic [31:0] H_MUL      = 32'd1284865837;
	localparam logic [31:0] H_SUB      = 32'd144211633;
	localparam logic [63:0] S_MIN      = 64'h8000000000000000;
	localparam logic [63:0] S_MAX      = 64'h7FFFFFFFFFFFFFFF;
	localparam logic [31:0] I_MIN      = 32'h80000000;
	localparam logic [31:0] I_MAX      = 32'h7FFFFFFF;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] x;
		logic [31:0] y;
		logic [12:0] bnd;
		logic [7:0]  a;
		logic [7:0]  b;
		logic [7:0]  c;
		logic [7:0]  d;
		logic        chk;
		logic [11:0] want;
	} word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  operation = lcp_pkg::OP_POS;
	logic signed [31:0] pos_x = '0;
	logic signed [31:0] pos_y = '0;
	logic [12:0] bound = '0;
	logic [7:0]  value_a = '0;
	logic [7:0]  value_b = '0;
	logic [7:0]  value_c = '0;
	logic [7:0]  value_d = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [11:0] result_value;

	// typed expectation riding along with a directed word
	logic        row_chk = 1'b0;
	logic [11:0] row_want = '0;

	// predictor state
	logic [63:0] reg_salt, reg_world, mix_salt, seed_lyr, run_val;
	logic [11:0] pending_results[$];
	logic [11:0] head;
	int          errors, words_in, results_seen, reg_writes, cycles;
	int          tx_idle, rx_idle;
	word_t       dir_tab[24];
	word_t       w;

	coordinate_seeded_lcg_picker #(.MAX_BOUND(MAX_BOUND)) i_dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [63:0] dup32(logic [31:0] v);
		return {v, v};
	endfunction

	function automatic void rederive();
		logic [63:0] s, a, b, m, v;
		s = reg_salt;
		a = s * (lcp_pkg::LCG_MUL * s + lcp_pkg::LCG_ADD) + s;
		b = (lcp_pkg::LCG_MUL * a + lcp_pkg::LCG_ADD) * a + s;
		m = b * (lcp_pkg::LCG_MUL * b + lcp_pkg::LCG_ADD) + s;
		v = {32'd0, reg_world[31:0]};
		v = v * (lcp_pkg::LCG_MUL * dup32(v[31:0]) + lcp_pkg::LCG_ADD) + m;
		v = v * (lcp_pkg::LCG_MUL * v + lcp_pkg::LCG_ADD) + m;
		v = v * (lcp_pkg::LCG_MUL * v + lcp_pkg::LCG_ADD) + m;
		mix_salt = m;
		seed_lyr = v;
	endfunction

	function automatic void hash_position(logic [31:0] x, logic [31:0] y);
		logic [63:0] xi, yi, v4, tmp, v6;
		logic [31:0] t, v5, lo;
		xi = {{32{x[31]}}, x};
		yi = {{32{y[31]}}, y};
		v4 = (lcp_pkg::LCG_MUL * seed_lyr + lcp_pkg::LCG_ADD) * seed_lyr + xi;
		tmp = v4 * ({32'd0, H_MUL} * v4 - {32'd0, H_SUB}) + yi;
		t = tmp[31:0];
		v5 = H_MUL * t - H_SUB;
		v6 = dup32(v5) * (v4 * (lcp_pkg::LCG_MUL * v4 + lcp_pkg::LCG_ADD) + yi) + xi;
		lo = H_MUL * v6[31:0] - H_SUB;
		run_val = dup32(lo) * v6 + yi;
	endfunction

	function automatic logic [11:0] draw_below(logic [12:0] lim);
		logic [63:0] bn, sh, rem;
		logic [11:0] r;
		bn = {51'd0, lim};
		if (bn == 0) bn = 1;
		if (bn > MAX_BOUND) bn = MAX_BOUND;
		sh = run_val >> 24;
		if (run_val[63]) begin
			sh |= 64'hFFFFFF0000000000;
			rem = (~sh + 64'd1) % bn;
			r = (rem == 0) ? 12'd0 : 12'(bn - rem);
		end else begin
			r = 12'(sh % bn);
		end
		run_val = run_val * (run_val * lcp_pkg::LCG_MUL + lcp_pkg::LCG_ADD) + seed_lyr;
		return r;
	endfunction

	function automatic logic [11:0] one_of_four(logic [7:0] a, logic [7:0] b,
		logic [7:0] c, logic [7:0] d);
		logic [11:0] r;
		r = draw_below(13'd4);
		case (r)
			12'd0: return {4'd0, a};
			12'd1: return {4'd0, b};
			12'd2: return {4'd0, c};
			default: return {4'd0, d};
		endcase
	endfunction

	function automatic logic [11:0] majority_or_pick(logic [7:0] i, logic [7:0] j,
		logic [7:0] k, logic [7:0] l);
		if (j == k && k == l) return {4'd0, j};
		if (i == j && (j == k || j == l)) return {4'd0, i};
		if (i == k && k == l) return {4'd0, i};
		if (i == j && k != l) return {4'd0, i};
		if (i == k && j != l) return {4'd0, i};
		if (i == l && j != k) return {4'd0, i};
		if (j == k && i != l) return {4'd0, j};
		if (j == l && i != k) return {4'd0, j};
		if (k == l && i != j) return {4'd0, k};
		return one_of_four(i, j, k, l);
	endfunction

	function automatic logic [11:0] lcg_predict(word_t x);
		logic [11:0] r;
		r = '0;
		case (x.op)
			lcp_pkg::OP_POS:   hash_position(x.x, x.y);
			lcp_pkg::OP_DRAW:  r = draw_below(x.bnd);
			lcp_pkg::OP_PICK2: r = (draw_below(13'd2) == 0) ? {4'd0, x.a} : {4'd0, x.b};
			lcp_pkg::OP_PICK4: r = one_of_four(x.a, x.b, x.c, x.d);
			lcp_pkg::OP_MODE:  r = majority_or_pick(x.a, x.b, x.c, x.d);
			default:           r = '0;
		endcase
		return r;
	endfunction

	// monitor: register writes, accepted words, results, in handshake order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_salt = '0;
			reg_world = '0;
			run_val = '0;
			rederive();
		end else begin
			cycles++;
			if (cycles > CYCLE_CAP) begin
				$display("[coordinate_seeded_lcg_picker] ERROR");
				$finish;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == lcp_pkg::REG_SALT) reg_salt = cfg_data;
				else reg_world = {32'd0, cfg_data[31:0]};
				rederive();
				reg_writes++;
			end
			if (in_valid && in_ready) begin
				head = lcg_predict('{operation, pos_x, pos_y, bound, value_a, value_b,
					value_c, value_d, 1'b0, 12'd0});
				pending_results.push_back(row_chk ? row_want : head);
				words_in++;
			end
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("result_value: nothing expected, got %0h", result_value);
					errors++;
				end else begin
					head = pending_results.pop_front();
					results_seen++;
					if (result_value !== head) begin
						$error("result_value: expected %0h, got %0h", head, result_value);
						errors++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	task automatic send_word(word_t x);
		if (tx_idle > 0 && $urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= x.op;
		pos_x <= x.x;
		pos_y <= x.y;
		bound <= x.bnd;
		value_a <= x.a;
		value_b <= x.b;
		value_c <= x.c;
		value_d <= x.d;
		row_chk <= x.chk;
		row_want <= x.want;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		row_chk <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [63:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic word_t random_word();
		word_t x;
		int    sel;
		logic [7:0] pool[3];
		x = '0;
		sel = $urandom_range(99);
		if (sel < 20) x.op = lcp_pkg::OP_POS;
		else if (sel < 50) x.op = lcp_pkg::OP_DRAW;
		else if (sel < 62) x.op = lcp_pkg::OP_PICK2;
		else if (sel < 74) x.op = lcp_pkg::OP_PICK4;
		else if (sel < 94) x.op = lcp_pkg::OP_MODE;
		else x.op = 3'($urandom_range(5, 7));
		x.x = $urandom;
		x.y = $urandom;
		if ($urandom_range(9) == 0) x.x = $urandom_range(1) ? I_MIN : I_MAX;
		if ($urandom_range(9) == 0) x.y = $urandom_range(1) ? I_MIN : I_MAX;
		sel = $urandom_range(9);
		if (sel < 6) x.bnd = 13'($urandom_range(1, MAX_BOUND));
		else if (sel < 8) x.bnd = 13'($urandom_range(0, 16));
		else x.bnd = 13'($urandom);
		// narrow value pool so majorities and ties happen often
		foreach (pool[n]) pool[n] = 8'($urandom);
		if ($urandom_range(9) < 7) begin
			x.a = pool[$urandom_range(2)];
			x.b = pool[$urandom_range(2)];
			x.c = pool[$urandom_range(2)];
			x.d = pool[$urandom_range(2)];
		end else begin
			x.a = 8'($urandom);
			x.b = 8'($urandom);
			x.c = 8'($urandom);
			x.d = 8'($urandom);
		end
		return x;
	endfunction

	initial begin
		logic [63:0] salts[5];
		logic [63:0] worlds[5];
		errors = 0;
		words_in = 0;
		results_seen = 0;
		reg_writes = 0;
		cycles = 0;
		tx_idle = 0;
		rx_idle = 0;
		// at reset the running value is zero, so draws give 0 and picks give a
		dir_tab = '{
			'{lcp_pkg::OP_DRAW,  '0, '0, 13'd4096, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 12'd0},
			'{lcp_pkg::OP_DRAW,  '0, '0, 13'd0,    8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 12'd0},
			'{lcp_pkg::OP_DRAW,  '0, '0, 13'd8191, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 12'd0},
			'{lcp_pkg::OP_PICK2, '0, '0, 13'd0, 8'h11, 8'h22, 8'd0, 8'd0, 1'b1, 12'h011},
			'{lcp_pkg::OP_PICK4, '0, '0, 13'd0, 8'hFF, 8'h01, 8'h02, 8'h03, 1'b1, 12'h0FF},
			'{lcp_pkg::OP_MODE,  '0, '0, 13'd0, 8'h07, 8'h09, 8'h09, 8'h09, 1'b1, 12'h009},
			'{OP_RSVD5,          '0, '0, 13'd0, 8'h55, 8'h55, 8'h55, 8'h55, 1'b1, 12'd0},
			'{lcp_pkg::OP_POS,   '0, '0, 13'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 12'd0},
			'{lcp_pkg::OP_POS,   I_MIN, I_MAX, 13'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 12'd0},
			'{lcp_pkg::OP_DRAW,  '0, '0, 13'd1,    8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 12'd0},
			'{lcp_pkg::OP_DRAW,  '0, '0, 13'd4096, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 12'd0},
			'{lcp_pkg::OP_DRAW,  '0, '0, 13'd4097, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 12'd0},
			'{lcp_pkg::OP_DRAW,  '0, '0, 13'd8191, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 12'd0},
			'{lcp_pkg::OP_DRAW,  '0, '0, 13'd0,    8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 12'd0},
			'{lcp_pkg::OP_POS,   I_MAX, I_MIN, 13'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 12'd0},
			'{lcp_pkg::OP_POS,   32'hFFFFFFFF, 32'h1, 13'd0, 8'd0, 8'd0, 8'd0, 8'd0,
				1'b1, 12'd0},
			'{lcp_pkg::OP_PICK2, '0, '0, 13'd0, 8'hA5, 8'h5A, 8'd0, 8'd0, 1'b0, 12'd0},
			'{lcp_pkg::OP_PICK4, '0, '0, 13'd0, 8'h10, 8'h20, 8'h30, 8'h40, 1'b0, 12'd0},
			'{lcp_pkg::OP_MODE,  '0, '0, 13'd0, 8'h01, 8'h02, 8'h03, 8'h04, 1'b0, 12'd0},
			'{lcp_pkg::OP_MODE,  '0, '0, 13'd0, 8'h01, 8'h02, 8'h01, 8'h02, 1'b0, 12'd0},
			'{lcp_pkg::OP_MODE,  '0, '0, 13'd0, 8'h05, 8'h05, 8'h06, 8'h07, 1'b1, 12'h005},
			'{lcp_pkg::OP_MODE,  '0, '0, 13'd0, 8'h03, 8'h04, 8'h05, 8'h05, 1'b1, 12'h005},
			'{OP_RSVD6,          '0, '0, 13'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 12'd0},
			'{OP_RSVD7,          '0, '0, 13'd1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 12'd0}
		};
		salts = '{S_MIN, S_MAX, 64'($urandom) << 32 | 64'($urandom), 64'd0,
			{$urandom, $urandom}};
		worlds = '{64'hFFFFFFFF, 64'd0, 64'($urandom), 64'($urandom), 64'hFFFFFFFF};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[n]) send_word(dir_tab[n]);

		for (int ph = 0; ph < 5; ph++) begin
			write_reg(lcp_pkg::REG_SALT, salts[ph]);
			write_reg(lcp_pkg::REG_WORLD, worlds[ph]);
			if (ph < 2) begin
				tx_idle = 15;
				rx_idle = 56;
			end else if (ph < 4) begin
				tx_idle = 56;
				rx_idle = 15;
			end else begin
				tx_idle = 0;
				rx_idle = 0;
			end
			for (int n = 0; n < CHUNK; n++) begin
				// hold the sender back until the pipe is empty once
				if (ph == 1 && n == CHUNK / 2) drain();
				w = random_word();
				send_word(w);
			end
		end
		drain();

		$display("%0d words and %0d results checked, %0d register writes over 5 settings",
			words_in, results_seen, reg_writes);
		$display("directed extremes, all operation codes, majority and tie cases covered");
		if (errors == 0) begin
			$display("[coordinate_seeded_lcg_picker] OK");
		end else begin
			$display("[coordinate_seeded_lcg_picker] ERROR");
		end
		$finish;
	end

endmodule

>>> filelist.f
hdl/lcp_pkg.sv
hdl/lcp_mac.sv
hdl/coordinate_seeded_lcg_picker.sv
dv/coordinate_seeded_lcg_picker_tb.sv
